// File: src/ts_packet_redundancy_selector_macros.svh
// Assertion macros shared by the redundancy selector RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef TS_PACKET_REDUNDANCY_SELECTOR_MACROS_SVH
`define TS_PACKET_REDUNDANCY_SELECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TPRS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tprs: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TPRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tprs: next-cycle check failed");

`endif

// File: src/tprs_pkg.sv
// Types, constants and header helpers for the redundancy selector.
// No dependencies; used by every module of the block.
`default_nettype none

package tprs_pkg;

  localparam int unsigned MAX_INPUTS = 4;
  localparam int unsigned PID_W      = 13;
  localparam int unsigned CC_W       = 4;
  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned PTR_W      = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W      = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0]       SYNC_BYTE = 8'h47;
  localparam logic [PID_W-1:0] NULL_PID  = 13'h1FFF;

  typedef enum logic [1:0] {
    SCORE_BAD_SYNC = 2'd0,
    SCORE_TEI      = 2'd1,
    SCORE_CC_ERR   = 2'd2,
    SCORE_CLEAN    = 2'd3
  } score_e;

  typedef struct packed {
    logic [31:0] header_in0;
    logic [31:0] header_in1;
    logic [31:0] header_in2;
    logic [31:0] header_in3;
    logic [3:0]  alive_mask;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] selected_input;
    logic [1:0] selected_score;
    logic       recovered;
    logic       out_tei;
    logic       out_cc_error;
    logic [3:0] tei_mask;
    logic [3:0] cc_error_mask;
  } out_beat_t;

  // Continuity table entry: valid flag plus last CC seen.
  typedef struct packed {
    logic            valid;
    logic [CC_W-1:0] cc;
  } cc_entry_t;

  // Clearing sweep after reset, broadcast to all tables.
  typedef struct packed {
    logic             active;
    logic [PID_W-1:0] addr;
  } clr_t;

  // What one lane reports to the merge stage.
  typedef struct packed {
    logic        alive;
    score_e      score;
    logic [31:0] hdr;
  } lane_res_t;

  function automatic logic hdr_sync(logic [31:0] h);
    return h[31:24] == SYNC_BYTE;
  endfunction

  function automatic logic hdr_tei(logic [31:0] h);
    return h[23];
  endfunction

  function automatic logic [PID_W-1:0] hdr_pid(logic [31:0] h);
    return h[20:8];
  endfunction

  function automatic logic [CC_W-1:0] hdr_cc(logic [31:0] h);
    return h[3:0];
  endfunction

  // PID is tracked: not the null PID and payload present.
  function automatic logic hdr_tracked(logic [31:0] h);
    return (h[20:8] != NULL_PID) && h[4];
  endfunction

  // Packet breaks continuity against a table entry (duplicate allowed).
  function automatic logic cc_breaks(logic [31:0] h, cc_entry_t e);
    logic [CC_W-1:0] nxt;
    nxt = e.cc + 4'd1;
    return hdr_tracked(h) && e.valid && (hdr_cc(h) != nxt) && (hdr_cc(h) != e.cc);
  endfunction

endpackage

`default_nettype wire

// File: src/tprs_lane.sv
// One capture lane: per-PID continuity table and packet scoring.
// Depends on tprs_pkg.
`default_nettype none

module tprs_lane (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tprs_pkg::clr_t      clr_i,
  input  wire logic                acc_i,
  input  wire logic                alive_i,
  input  wire logic [31:0]         hdr_i,
  output tprs_pkg::lane_res_t      res_o
);

  localparam int unsigned DEPTH = 2 ** tprs_pkg::PID_W;

  tprs_pkg::cc_entry_t mem_q [DEPTH];
  tprs_pkg::cc_entry_t rd_q;
  logic [31:0]         hdr_q;
  logic                live_q;

  logic                   we;
  logic [tprs_pkg::PID_W-1:0] wpid;
  logic [tprs_pkg::PID_W-1:0] rpid;
  tprs_pkg::cc_entry_t    wdata;
  tprs_pkg::score_e       score;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= acc_i & alive_i;
    end
  end

  assign wpid  = tprs_pkg::hdr_pid(hdr_q);
  assign rpid  = tprs_pkg::hdr_pid(hdr_i);
  assign wdata = '{valid: 1'b1, cc: tprs_pkg::hdr_cc(hdr_q)};
  // Only clean-sync, TEI-clear, tracked packets update history.
  assign we    = live_q && tprs_pkg::hdr_sync(hdr_q) && !tprs_pkg::hdr_tei(hdr_q)
                 && tprs_pkg::hdr_tracked(hdr_q);

  always_ff @(posedge clk_i) begin
    if (clr_i.active) begin
      mem_q[clr_i.addr] <= '0;
    end else if (we) begin
      mem_q[wpid] <= wdata;
    end
  end

  // Read at accept; bypass the write landing on the same edge.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      hdr_q <= hdr_i;
      if (we && (wpid == rpid)) begin
        rd_q <= wdata;
      end else begin
        rd_q <= mem_q[rpid];
      end
    end
  end

  always_comb begin
    if (!tprs_pkg::hdr_sync(hdr_q)) begin
      score = tprs_pkg::SCORE_BAD_SYNC;
    end else if (tprs_pkg::hdr_tei(hdr_q)) begin
      score = tprs_pkg::SCORE_TEI;
    end else if (tprs_pkg::cc_breaks(hdr_q, rd_q)) begin
      score = tprs_pkg::SCORE_CC_ERR;
    end else begin
      score = tprs_pkg::SCORE_CLEAN;
    end
  end

  assign res_o = '{alive: live_q, score: score, hdr: hdr_q};

endmodule

`default_nettype wire

// File: src/tprs_merge.sv
// Merge stage: picks the best lane, then checks the output stream's continuity.
// Depends on tprs_pkg and the assertion macro header.
`default_nettype none
`include "ts_packet_redundancy_selector_macros.svh"

module tprs_merge (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tprs_pkg::clr_t      clr_i,
  input  wire logic                a_valid_i,
  input  wire tprs_pkg::lane_res_t lanes_i [tprs_pkg::MAX_INPUTS],
  output logic                     push_o,
  output tprs_pkg::out_beat_t      beat_o
);

  localparam int unsigned DEPTH = 2 ** tprs_pkg::PID_W;

  // Selection, combinational over the lane results
  logic             found;
  logic [1:0]       best;
  tprs_pkg::score_e best_sc;
  logic             recov;
  logic [3:0]       tei_m;
  logic [3:0]       cc_m;
  logic [31:0]      sel_hdr;

  always_comb begin
    found   = 1'b0;
    best    = 2'd0;
    best_sc = tprs_pkg::SCORE_BAD_SYNC;
    tei_m   = '0;
    cc_m    = '0;
    for (int i = 0; i < tprs_pkg::MAX_INPUTS; i++) begin
      if (lanes_i[i].alive) begin
        if (!found || (lanes_i[i].score > best_sc)) begin
          best    = 2'(i);
          best_sc = lanes_i[i].score;
          found   = 1'b1;
        end
        if (lanes_i[i].score == tprs_pkg::SCORE_TEI) tei_m[i] = 1'b1;
        if (lanes_i[i].score == tprs_pkg::SCORE_CC_ERR) cc_m[i] = 1'b1;
      end
    end
    recov = 1'b0;
    for (int i = 0; i < tprs_pkg::MAX_INPUTS; i++) begin
      if (lanes_i[i].alive && (2'(i) != best) && (lanes_i[i].score < best_sc)
          && (best_sc >= tprs_pkg::SCORE_CC_ERR)) begin
        recov = 1'b1;
      end
    end
  end

  assign sel_hdr = lanes_i[best].hdr;

  // Stage B
  logic                b_valid_q;
  logic                b_found_q;
  logic [1:0]          b_best_q;
  tprs_pkg::score_e    b_score_q;
  logic                b_recov_q;
  logic [3:0]          b_tei_q;
  logic [3:0]          b_cc_q;
  logic [31:0]         b_hdr_q;
  tprs_pkg::cc_entry_t b_rd_q;
  tprs_pkg::cc_entry_t mem_q [DEPTH];

  logic                       b_chk;
  logic                       we;
  logic [tprs_pkg::PID_W-1:0] wpid;
  logic [tprs_pkg::PID_W-1:0] rpid;
  tprs_pkg::cc_entry_t        wdata;

  assign b_chk = b_found_q && tprs_pkg::hdr_sync(b_hdr_q);
  assign wpid  = tprs_pkg::hdr_pid(b_hdr_q);
  assign rpid  = tprs_pkg::hdr_pid(sel_hdr);
  assign wdata = '{valid: 1'b1, cc: tprs_pkg::hdr_cc(b_hdr_q)};
  // Forwarded packet updates output history whatever its TEI.
  assign we    = b_valid_q && b_chk && tprs_pkg::hdr_tracked(b_hdr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    b_found_q <= found;
    b_best_q  <= best;
    b_score_q <= best_sc;
    b_recov_q <= recov;
    b_tei_q   <= tei_m;
    b_cc_q    <= cc_m;
    b_hdr_q   <= sel_hdr;
    if (we && (wpid == rpid)) begin
      b_rd_q <= wdata;
    end else begin
      b_rd_q <= mem_q[rpid];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_i.active) begin
      mem_q[clr_i.addr] <= '0;
    end else if (we) begin
      mem_q[wpid] <= wdata;
    end
  end

  assign push_o = b_valid_q;
  assign beat_o = '{
    selected_input: b_best_q,
    selected_score: b_score_q,
    recovered:      b_recov_q,
    out_tei:        b_chk && tprs_pkg::hdr_tei(b_hdr_q),
    out_cc_error:   b_chk && tprs_pkg::cc_breaks(b_hdr_q, b_rd_q),
    tei_mask:       b_tei_q,
    cc_error_mask:  b_cc_q
  };

  `TPRS_ASSERT_NOW(a_recov_needs_good, clk_i, rst_ni, push_o && beat_o.recovered, beat_o.selected_score >= tprs_pkg::SCORE_CC_ERR)

endmodule

`default_nettype wire

// File: src/tprs_fifo.sv
// Small result queue that decouples the output side from the pipeline.
// Depends on tprs_pkg and the assertion macro header.
`default_nettype none
`include "ts_packet_redundancy_selector_macros.svh"

module tprs_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tprs_pkg::out_beat_t data_i,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output tprs_pkg::out_beat_t      data_o
);

  tprs_pkg::out_beat_t            mem_q [tprs_pkg::OUT_DEPTH];
  logic [tprs_pkg::PTR_W-1:0]     wr_q;
  logic [tprs_pkg::PTR_W-1:0]     rd_q;
  logic [tprs_pkg::CNT_W-1:0]     cnt_q;
  logic                           pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop)    rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + tprs_pkg::CNT_W'(push_i) - tprs_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Upstream credit keeps the queue from overflowing.
  `TPRS_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push_i && !pop, cnt_q != tprs_pkg::CNT_W'(tprs_pkg::OUT_DEPTH))

endmodule

`default_nettype wire

// File: src/ts_packet_redundancy_selector.sv
// Redundant transport stream packet selector. Each beat carries the first four
// header bytes of the packet at one position in up to NUM_INPUTS captures plus
// an alive mask; the block scores each alive packet (bad sync, TEI, continuity
// error, clean) in parallel lanes against that capture's per-PID continuity
// table, forwards the best (lowest index on a tie), flags recovery, and checks
// continuity of the forwarded stream against an output table. A new beat is
// taken every cycle while in_stall_o is low; each accepted beat passes through
// lane table read, lane score and selection with output table read, and output
// check into a four-entry result queue, from which out_valid_o offers it. Every
// table is a single-port style memory written in the cycle after it is read,
// with a write-to-read bypass so back-to-back packets on the same PID see the
// fresh entry. After reset a clearing sweep wipes all tables at one PID per
// cycle; in_stall_o stays high throughout the sweep. in_stall_o also rises
// when the result queue plus beats in flight would exceed four.
// Depends on tprs_pkg, tprs_lane, tprs_merge, tprs_fifo and the macro header.
`default_nettype none
`include "ts_packet_redundancy_selector_macros.svh"

module ts_packet_redundancy_selector #(
  parameter int unsigned NUM_INPUTS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tprs_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tprs_pkg::out_beat_t      out_data_o
);

  localparam logic [tprs_pkg::CNT_W-1:0] FULL = tprs_pkg::CNT_W'(tprs_pkg::OUT_DEPTH);

  // Clearing sweep over all PIDs after reset.
  logic                       clr_active_q;
  logic [tprs_pkg::PID_W-1:0] clr_addr_q;
  tprs_pkg::clr_t             clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) clr_active_q <= 1'b0;
    end
  end

  assign clr = '{active: clr_active_q, addr: clr_addr_q};

  // Credit: beats accepted whose results have not left the queue yet.
  logic [tprs_pkg::CNT_W-1:0] res_q;
  logic                       acc;
  logic                       pop;
  logic                       a_valid_q;

  assign in_stall_o = clr_active_q || (res_q == FULL);
  assign acc        = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      res_q     <= res_q + tprs_pkg::CNT_W'(acc) - tprs_pkg::CNT_W'(pop);
      a_valid_q <= acc;
    end
  end

  // Lanes
  logic [tprs_pkg::MAX_INPUTS-1:0][31:0] hdrs;
  tprs_pkg::lane_res_t                   lane_res [tprs_pkg::MAX_INPUTS];

  assign hdrs = {in_data_i.header_in3, in_data_i.header_in2,
                 in_data_i.header_in1, in_data_i.header_in0};

  for (genvar i = 0; i < tprs_pkg::MAX_INPUTS; i++) begin : g_lane
    if (i < NUM_INPUTS) begin : g_on
      tprs_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .clr_i   (clr),
        .acc_i   (acc),
        .alive_i (in_data_i.alive_mask[i]),
        .hdr_i   (hdrs[i]),
        .res_o   (lane_res[i])
      );
    end else begin : g_off
      // Capture not built: never alive.
      assign lane_res[i] = '0;
    end
  end

  // Selection and output continuity
  logic                push;
  tprs_pkg::out_beat_t beat;

  tprs_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .a_valid_i (a_valid_q),
    .lanes_i   (lane_res),
    .push_o    (push),
    .beat_o    (beat)
  );

  tprs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (beat),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  `TPRS_ASSERT_NOW(a_credit_bound, clk_i, rst_ni, 1'b1, res_q <= FULL)
  `TPRS_ASSERT_NOW(a_out_has_credit, clk_i, rst_ni, out_valid_o, res_q != '0)
  `TPRS_ASSERT_NEXT(a_clear_once, clk_i, rst_ni, !clr_active_q, !clr_active_q)

endmodule

`default_nettype wire

// File: tb/sv/ts_packet_redundancy_selector_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the redundant TS packet selector: directed and random header beats.
// A scoreboard class tracks every continuity table. Depends on tprs_pkg and the selector.

module ts_packet_redundancy_selector_tb;

  localparam int unsigned NUM_CAPTURES = 4;
  localparam int unsigned PID_SPAN     = 8192;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_BEATS = 1200;
  localparam int unsigned MAX_WAIT     = 14;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned POOL_SIZE    = 8;

  // Scoreboard: mirrors the per-capture and output continuity tables and
  // predicts one selection per accepted header beat.
  class selector_scoreboard;
    tprs_pkg::cc_entry_t cap_hist [NUM_CAPTURES][PID_SPAN];
    tprs_pkg::cc_entry_t fwd_hist [PID_SPAN];
    tprs_pkg::out_beat_t pending_selections [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned recoveries;
    int unsigned fwd_tei;
    int unsigned fwd_breaks;
    int unsigned cap_breaks;

    function new();
      foreach (cap_hist[c, p]) cap_hist[c][p] = '0;
      foreach (fwd_hist[p]) fwd_hist[p] = '0;
      mismatches = 0;
      checked    = 0;
      recoveries = 0;
      fwd_tei    = 0;
      fwd_breaks = 0;
      cap_breaks = 0;
    endfunction

    // Continuity applies to non-null PIDs carrying payload.
    function bit is_tracked(logic [31:0] h);
      return (h[20:8] != tprs_pkg::NULL_PID) && h[4];
    endfunction

    // Break: entry known and CC is neither a repeat nor last+1.
    function bit run_broken(logic [31:0] h, tprs_pkg::cc_entry_t e);
      logic [3:0] nxt;
      nxt = e.cc + 4'd1;
      if (!e.valid || !is_tracked(h)) return 1'b0;
      return (h[3:0] != e.cc) && (h[3:0] != nxt);
    endfunction

    function void note_packet(tprs_pkg::in_beat_t b);
      logic [31:0]         hdr [NUM_CAPTURES];
      tprs_pkg::score_e    sc  [NUM_CAPTURES];
      logic [3:0]          alive;
      logic [31:0]         fh;
      tprs_pkg::out_beat_t sel;
      int                  best;
      bit                  found;
      hdr[0] = b.header_in0;
      hdr[1] = b.header_in1;
      hdr[2] = b.header_in2;
      hdr[3] = b.header_in3;
      alive  = b.alive_mask & 4'((1 << NUM_CAPTURES) - 1);
      sel    = '0;
      best   = 0;
      found  = 1'b0;
      if (alive != 4'd0) begin
        // score every live capture against its own history, pre-update
        for (int i = 0; i < NUM_CAPTURES; i++) begin
          sc[i] = tprs_pkg::SCORE_BAD_SYNC;
          if (!alive[i]) continue;
          if (hdr[i][31:24] != tprs_pkg::SYNC_BYTE) sc[i] = tprs_pkg::SCORE_BAD_SYNC;
          else if (hdr[i][23]) sc[i] = tprs_pkg::SCORE_TEI;
          else if (run_broken(hdr[i], cap_hist[i][hdr[i][20:8]]))
            sc[i] = tprs_pkg::SCORE_CC_ERR;
          else sc[i] = tprs_pkg::SCORE_CLEAN;
          if (!found || sc[i] > sc[best]) begin
            best  = i;
            found = 1'b1;
          end
          sel.tei_mask[i]      = (sc[i] == tprs_pkg::SCORE_TEI);
          sel.cc_error_mask[i] = (sc[i] == tprs_pkg::SCORE_CC_ERR);
        end
        if (sc[best] >= tprs_pkg::SCORE_CC_ERR) begin
          for (int j = 0; j < NUM_CAPTURES; j++) begin
            if (j != best && alive[j] && sc[j] < sc[best]) sel.recovered = 1'b1;
          end
        end
        // capture tables learn only from clean-TEI synced packets
        for (int i = 0; i < NUM_CAPTURES; i++) begin
          if (alive[i] && hdr[i][31:24] == tprs_pkg::SYNC_BYTE && !hdr[i][23]
              && is_tracked(hdr[i]))
            cap_hist[i][hdr[i][20:8]] = {1'b1, hdr[i][3:0]};
        end
        // output stream check, TEI does not block the update here
        fh = hdr[best];
        if (fh[31:24] == tprs_pkg::SYNC_BYTE) begin
          sel.out_tei      = fh[23];
          sel.out_cc_error = run_broken(fh, fwd_hist[fh[20:8]]);
          if (is_tracked(fh)) fwd_hist[fh[20:8]] = {1'b1, fh[3:0]};
        end
        sel.selected_input = 2'(best);
        sel.selected_score = sc[best];
      end
      pending_selections = {pending_selections, sel};
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        flag_mismatch($sformatf("%s got %0d want %0d (selection %0d)", name, got, want,
                                checked));
    endtask

    task check_result(tprs_pkg::out_beat_t r);
      tprs_pkg::out_beat_t w;
      if (pending_selections.size() == 0) begin
        flag_mismatch($sformatf("selection beat %h with nothing outstanding", r));
        return;
      end
      w = pending_selections.pop_front();
      compare_field("selected_input", r.selected_input, w.selected_input);
      compare_field("selected_score", r.selected_score, w.selected_score);
      compare_field("recovered", r.recovered, w.recovered);
      compare_field("out_tei", r.out_tei, w.out_tei);
      compare_field("out_cc_error", r.out_cc_error, w.out_cc_error);
      compare_field("tei_mask", r.tei_mask, w.tei_mask);
      compare_field("cc_error_mask", r.cc_error_mask, w.cc_error_mask);
      checked++;
      recoveries += w.recovered;
      fwd_tei    += w.out_tei;
      fwd_breaks += w.out_cc_error;
      if (w.cc_error_mask != 4'd0) cap_breaks++;
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  tprs_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  tprs_pkg::out_beat_t out_data;

  selector_scoreboard scoreboard;
  tprs_pkg::in_beat_t stimulus_beats [$];
  int unsigned        directed_count;

  // Generator state: a handful of live PIDs, each with its running CC.
  logic [12:0] pid_pool  [POOL_SIZE];
  logic [3:0]  stream_cc [POOL_SIZE];

  ts_packet_redundancy_selector #(
    .NUM_INPUTS(NUM_CAPTURES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // sync, TEI, PID, payload flag, CC; the remaining header bits stay zero
  function automatic logic [31:0] make_hdr(logic [7:0] sync, bit tei, logic [12:0] pid,
                                           bit pay, logic [3:0] cc);
    return {sync, tei, 2'b00, pid, 2'b00, 1'b0, pay, cc};
  endfunction

  function automatic void add_beat(logic [31:0] h0, logic [31:0] h1, logic [31:0] h2,
                                   logic [31:0] h3, logic [3:0] mask);
    tprs_pkg::in_beat_t b;
    b.header_in0 = h0;
    b.header_in1 = h1;
    b.header_in2 = h2;
    b.header_in3 = h3;
    b.alive_mask = mask;
    stimulus_beats = {stimulus_beats, b};
  endfunction

  // Mostly one well-formed stream copied to every capture, each copy damaged
  // now and then (sync, TEI, CC, garbage); some beats are pure noise.
  function automatic tprs_pkg::in_beat_t random_beat();
    tprs_pkg::in_beat_t b;
    logic [31:0]        base;
    logic [31:0]        h [NUM_CAPTURES];
    int                 k;
    int                 roll;
    bit                 pay;
    if ($urandom_range(0, 99) < 8) begin
      b.header_in0 = $urandom();
      b.header_in1 = $urandom();
      b.header_in2 = $urandom();
      b.header_in3 = $urandom();
      b.alive_mask = 4'($urandom_range(1, 15));
      return b;
    end
    k    = $urandom_range(0, POOL_SIZE - 1);
    roll = $urandom_range(0, 99);
    if (roll < 80) stream_cc[k] += 4'd1;           // normal advance
    else if (roll >= 90) stream_cc[k] = 4'($urandom()); // discontinuity
    // otherwise a duplicate
    pay  = ($urandom_range(0, 9) != 0);
    base = {tprs_pkg::SYNC_BYTE, 1'b0, 2'($urandom()), pid_pool[k], 2'($urandom()),
            1'($urandom()), pay, stream_cc[k]};
    for (int c = 0; c < NUM_CAPTURES; c++) begin
      h[c] = base;
      roll = $urandom_range(0, 99);
      if (roll < 7) h[c][31:24] = 8'($urandom());
      else if (roll < 14) h[c][23] = 1'b1;
      else if (roll < 20) h[c][3:0] = 4'($urandom());
      else if (roll < 22) h[c] = $urandom();
    end
    b.header_in0 = h[0];
    b.header_in1 = h[1];
    b.header_in2 = h[2];
    b.header_in3 = h[3];
    b.alive_mask = ($urandom_range(0, 3) != 0) ? 4'hF : 4'($urandom_range(1, 15));
    return b;
  endfunction

  // Sender: random gaps between beats, with calm stretches of back-to-back beats.
  task automatic send_beats();
    int gap;
    bit calm;
    calm = 1'b0;
    foreach (stimulus_beats[n]) begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_data  <= stimulus_beats[n];
      do @(posedge clk); while (in_stall);
      scoreboard.note_packet(stimulus_beats[n]);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver: stalls a random number of cycles before taking each result beat.
  initial begin : result_sink
    int hold;
    bit calm;
    calm = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      scoreboard.check_result(out_data);
    end
  end

  initial begin : main_seq
    logic [12:0] pa;
    logic [12:0] pb;
    logic [7:0]  sb;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    scoreboard = new();
    pa = 13'h0100;
    pb = 13'h1ABC;
    sb = tprs_pkg::SYNC_BYTE;

    // directed: continuity basics on PID A
    add_beat(make_hdr(sb, 0, pa, 1, 4'd0), make_hdr(sb, 0, pa, 1, 4'd0),
             make_hdr(sb, 0, pa, 1, 4'd0), make_hdr(sb, 0, pa, 1, 4'd0), 4'hF);
    add_beat(make_hdr(sb, 0, pa, 1, 4'd1), make_hdr(sb, 0, pa, 1, 4'd1),
             make_hdr(sb, 0, pa, 1, 4'd1), make_hdr(sb, 0, pa, 1, 4'd1), 4'hF);
    // duplicate CC is allowed
    add_beat(make_hdr(sb, 0, pa, 1, 4'd1), make_hdr(sb, 0, pa, 1, 4'd1),
             make_hdr(sb, 0, pa, 1, 4'd1), make_hdr(sb, 0, pa, 1, 4'd1), 4'hF);
    // one of each score, clean copy sits last: recovery
    add_beat(make_hdr(8'h00, 0, pa, 1, 4'd2), make_hdr(sb, 1, pa, 1, 4'd2),
             make_hdr(sb, 0, pa, 1, 4'd9), make_hdr(sb, 0, pa, 1, 4'd2), 4'hF);
    // every copy a CC break: tie at score two goes to capture 0
    add_beat(make_hdr(sb, 0, pa, 1, 4'd12), make_hdr(sb, 0, pa, 1, 4'd12),
             make_hdr(sb, 0, pa, 1, 4'd12), make_hdr(sb, 0, pa, 1, 4'd12), 4'hF);
    // all bad sync, lowest live capture forwarded
    add_beat(32'h0, 32'h48000000, 32'hFF000000, 32'h46000000, 4'b0110);
    // nothing alive
    add_beat(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'h0);
    // all TEI
    add_beat(make_hdr(sb, 1, pa, 1, 4'd13), make_hdr(sb, 1, pa, 1, 4'd13),
             make_hdr(sb, 1, pa, 1, 4'd13), make_hdr(sb, 1, pa, 1, 4'd13), 4'hF);
    // null PID and payload-less packets bypass continuity
    add_beat(make_hdr(sb, 0, tprs_pkg::NULL_PID, 1, 4'd5),
             make_hdr(sb, 0, tprs_pkg::NULL_PID, 1, 4'd7),
             make_hdr(sb, 0, tprs_pkg::NULL_PID, 1, 4'd5),
             make_hdr(sb, 0, tprs_pkg::NULL_PID, 1, 4'd0), 4'hF);
    add_beat(make_hdr(sb, 0, pa, 0, 4'd7), make_hdr(sb, 0, pa, 0, 4'd3),
             make_hdr(sb, 0, pa, 0, 4'd7), make_hdr(sb, 0, pa, 0, 4'd7), 4'hF);
    // extreme words
    add_beat(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF);
    add_beat(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 4'hF);
    add_beat(32'h47FFFFFF, 32'h477FFFFF, 32'h47000000, 32'h477FFFEF, 4'hF);
    // CC wrap on PID B
    add_beat(make_hdr(sb, 0, pb, 1, 4'd14), make_hdr(sb, 0, pb, 1, 4'd14),
             make_hdr(sb, 0, pb, 1, 4'd14), make_hdr(sb, 0, pb, 1, 4'd14), 4'hF);
    add_beat(make_hdr(sb, 0, pb, 1, 4'd15), make_hdr(sb, 0, pb, 1, 4'd15),
             make_hdr(sb, 0, pb, 1, 4'd15), make_hdr(sb, 0, pb, 1, 4'd15), 4'hF);
    add_beat(make_hdr(sb, 0, pb, 1, 4'd0), make_hdr(sb, 0, pb, 1, 4'd0),
             make_hdr(sb, 0, pb, 1, 4'd0), make_hdr(sb, 0, pb, 1, 4'd0), 4'hF);
    // capture 0 alone runs ahead, then capture 1 lags: output stream breaks
    for (int c = 1; c <= 3; c++)
      add_beat(make_hdr(sb, 0, pb, 1, 4'(c)), 32'h0, 32'h0, 32'h0, 4'b0001);
    add_beat(32'h0, make_hdr(sb, 0, pb, 1, 4'd1), make_hdr(8'h00, 0, pb, 1, 4'd1),
             make_hdr(sb, 1, pb, 1, 4'd1), 4'b1110);
    // single live captures
    for (int c = 0; c < NUM_CAPTURES; c++)
      add_beat(make_hdr(sb, 0, pa, 1, 4'd14), make_hdr(sb, 0, pa, 1, 4'd14),
               make_hdr(sb, 0, pa, 1, 4'd14), make_hdr(sb, 0, pa, 1, 4'd14),
               4'(1 << c));
    directed_count = stimulus_beats.size();

    // PID pool covers both ends of the PID range plus the null PID
    pid_pool[0] = 13'h0000;
    pid_pool[1] = 13'h1FFE;
    pid_pool[2] = tprs_pkg::NULL_PID;
    for (int k = 3; k < POOL_SIZE; k++) pid_pool[k] = 13'($urandom());
    for (int k = 0; k < POOL_SIZE; k++) stream_cc[k] = 4'($urandom());
    repeat (RANDOM_BEATS) stimulus_beats = {stimulus_beats, random_beat()};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // the block holds in_stall through its table-clearing sweep
    send_beats();
    while (scoreboard.pending_selections.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d selections from %0d header beats (%0d directed).",
             scoreboard.checked, stimulus_beats.size(), directed_count);
    $display("Seen: %0d recoveries, %0d forwarded TEI, %0d output CC breaks, %0d capture CC breaks.",
             scoreboard.recoveries, scoreboard.fwd_tei, scoreboard.fwd_breaks,
             scoreboard.cap_breaks);
    if (scoreboard.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: well past the slowest legal run including the clearing sweep.
  initial begin : watchdog
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/tprs_pkg.sv
src/tprs_lane.sv
src/tprs_merge.sv
src/tprs_fifo.sv
src/ts_packet_redundancy_selector.sv
tb/sv/ts_packet_redundancy_selector_tb.sv
